[hw/rtl/cdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation codes, word width, default depth and the per-cell command bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;

    localparam logic signed [WORD_W-1:0] MINUS_ONE = '1;

    // Chain A keeps the deque front-first, chain B keeps it rear-first.
    typedef struct packed {
        logic a_shr;  // shift toward higher cells, cell 0 loads the beat value
        logic a_shl;  // shift toward cell 0
        logic a_wr;   // the cell at the fill level loads the beat value
        logic b_shr;
        logic b_shl;
        logic b_wr;
    } cell_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/cdq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque row
// Holds one word of each chain and takes a neighbor word or the beat value.
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  wire                                  clk,
    input  cdq_pkg::cell_cmd_t                   cmd,
    input  wire         [CNT_W-1:0]              fill,
    input  wire  signed [cdq_pkg::WORD_W-1:0]    value,
    input  wire  signed [cdq_pkg::WORD_W-1:0]    a_left,
    input  wire  signed [cdq_pkg::WORD_W-1:0]    a_right,
    input  wire  signed [cdq_pkg::WORD_W-1:0]    b_left,
    input  wire  signed [cdq_pkg::WORD_W-1:0]    b_right,
    output logic signed [cdq_pkg::WORD_W-1:0]    a_word,
    output logic signed [cdq_pkg::WORD_W-1:0]    b_word
);

    logic signed [cdq_pkg::WORD_W-1:0] a_reg;
    logic signed [cdq_pkg::WORD_W-1:0] a_next;
    logic signed [cdq_pkg::WORD_W-1:0] b_reg;
    logic signed [cdq_pkg::WORD_W-1:0] b_next;
    logic                              at_fill;

    assign at_fill = (fill == CNT_W'(IDX));

    always_comb
    begin
        a_next = a_reg;
        if (cmd.a_shr)
        begin
            a_next = a_left;
        end
        else if (cmd.a_shl)
        begin
            a_next = a_right;
        end
        else if (cmd.a_wr && at_fill)
        begin
            a_next = value;
        end

        b_next = b_reg;
        if (cmd.b_shr)
        begin
            b_next = b_left;
        end
        else if (cmd.b_shl)
        begin
            b_next = b_right;
        end
        else if (cmd.b_wr && at_fill)
        begin
            b_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_word = a_reg;
    assign b_word = b_reg;

endmodule
`default_nettype wire

[hw/rtl/circular_deque_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue of signed 32-bit words
// A row of cells holds two copies of the deque, one front-first and one
// rear-first; both ends sit in cell 0 and every operation shifts one chain.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   operation, item_value
//   out      source     out_valid / out_stall accepted, popped_value,
//                                             front_value, rear_value,
//                                             is_empty, is_full
//
// One beat per clock unless in_stall is high: the whole cell row updates
// in the cycle a beat is accepted and its result is registered for the next cycle.
// in_stall rises only while a result waits in the output register.
// Reset empties the deque at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire         [cdq_pkg::OP_W-1:0]     operation,
    input  wire  signed [cdq_pkg::WORD_W-1:0]   item_value,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic                                accepted,
    output logic signed [cdq_pkg::WORD_W-1:0]   popped_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   front_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   rear_value,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int              CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic signed [cdq_pkg::WORD_W-1:0] a_word [DEPTH];
    logic signed [cdq_pkg::WORD_W-1:0] b_word [DEPTH];

    cdq_pkg::cell_cmd_t cmd;

    logic                 in_acc;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 empty_now;
    logic                 last_now;
    logic                 push_front_ok;
    logic                 push_rear_ok;
    logic                 pop_front_ok;
    logic                 pop_rear_ok;
    logic                 ok;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              accepted_reg;
    logic signed [cdq_pkg::WORD_W-1:0] popped_reg;
    logic signed [cdq_pkg::WORD_W-1:0] front_reg;
    logic signed [cdq_pkg::WORD_W-1:0] rear_reg;
    logic                              empty_reg;
    logic                              full_reg;
    logic signed [cdq_pkg::WORD_W-1:0] popped_next;
    logic signed [cdq_pkg::WORD_W-1:0] front_next;
    logic signed [cdq_pkg::WORD_W-1:0] rear_next;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign empty_now = (count_reg == '0);
    assign last_now  = (count_reg == ONE_CNT);

    assign push_front_ok = in_acc && (operation == cdq_pkg::OP_PUSH_FRONT)
                           && (count_reg != FULL_CNT);
    assign push_rear_ok  = in_acc && (operation == cdq_pkg::OP_PUSH_REAR)
                           && (count_reg != FULL_CNT);
    assign pop_front_ok  = in_acc && (operation == cdq_pkg::OP_POP_FRONT) && !empty_now;
    assign pop_rear_ok   = in_acc && (operation == cdq_pkg::OP_POP_REAR) && !empty_now;
    assign ok = push_front_ok || push_rear_ok || pop_front_ok || pop_rear_ok;

    // A push at one end shifts its own chain and drops the word at the fill
    // level of the other chain.
    assign cmd.a_shr = push_front_ok;
    assign cmd.a_shl = pop_front_ok;
    assign cmd.a_wr  = push_rear_ok;
    assign cmd.b_shr = push_rear_ok;
    assign cmd.b_shl = pop_rear_ok;
    assign cmd.b_wr  = push_front_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [cdq_pkg::WORD_W-1:0] a_left;
            logic signed [cdq_pkg::WORD_W-1:0] a_right;
            logic signed [cdq_pkg::WORD_W-1:0] b_left;
            logic signed [cdq_pkg::WORD_W-1:0] b_right;

            if (gi == 0)
            begin : g_first
                assign a_left = item_value;
                assign b_left = item_value;
            end
            else
            begin : g_mid
                assign a_left = a_word[gi-1];
                assign b_left = b_word[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign a_right = a_word[gi];
                assign b_right = b_word[gi];
            end
            else
            begin : g_inner
                assign a_right = a_word[gi+1];
                assign b_right = b_word[gi+1];
            end

            cdq_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk     (clk),
                .cmd     (cmd),
                .fill    (count_reg),
                .value   (item_value),
                .a_left  (a_left),
                .a_right (a_right),
                .b_left  (b_left),
                .b_right (b_right),
                .a_word  (a_word[gi]),
                .b_word  (b_word[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (push_front_ok || push_rear_ok)
        begin
            count_next = count_reg + ONE_CNT;
        end
        else if (pop_front_ok || pop_rear_ok)
        begin
            count_next = count_reg - ONE_CNT;
        end
    end

    // Ends of the deque as they stand after this beat.
    always_comb
    begin
        popped_next = cdq_pkg::MINUS_ONE;
        front_next  = empty_now ? cdq_pkg::MINUS_ONE : a_word[0];
        rear_next   = empty_now ? cdq_pkg::MINUS_ONE : b_word[0];
        if (push_front_ok)
        begin
            front_next = item_value;
            rear_next  = empty_now ? item_value : b_word[0];
        end
        else if (push_rear_ok)
        begin
            front_next = empty_now ? item_value : a_word[0];
            rear_next  = item_value;
        end
        else if (pop_front_ok)
        begin
            popped_next = a_word[0];
            front_next  = last_now ? cdq_pkg::MINUS_ONE : a_word[1];
            rear_next   = last_now ? cdq_pkg::MINUS_ONE : b_word[0];
        end
        else if (pop_rear_ok)
        begin
            popped_next = b_word[0];
            front_next  = last_now ? cdq_pkg::MINUS_ONE : a_word[0];
            rear_next   = last_now ? cdq_pkg::MINUS_ONE : b_word[1];
        end
    end

    assign out_valid_next = in_acc || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            accepted_reg <= ok;
            popped_reg   <= popped_next;
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next == FULL_CNT);
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign popped_value = popped_reg;
    assign front_value  = front_reg;
    assign rear_value   = rear_reg;
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("deque fill level beyond depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(empty_reg && full_reg))
        else $error("result flags both empty and full");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(count_reg))
        else $error("fill level moved without an input beat");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ((operation == cdq_pkg::OP_PUSH_FRONT)
                 || (operation == cdq_pkg::OP_PUSH_REAR)))
        |=> (!empty_reg && out_valid_reg))
        else $error("push beat left the deque empty");

    a_pop_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && empty_now && ((operation == cdq_pkg::OP_POP_FRONT)
                              || (operation == cdq_pkg::OP_POP_REAR)))
        |=> (!accepted_reg && (popped_reg == cdq_pkg::MINUS_ONE)))
        else $error("pop from empty deque not refused");

endmodule
`default_nettype wire
